FILE: rtl/sss_pkg.sv
// Shared types of the sorted set store: command codes and controller/datapath interface.
package sss_pkg;

  typedef enum logic [1:0] {
    CMD_QUERY  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic load;
    logic srch_cmp;
    logic mv_init;
    logic mv_rd;
    logic mv_wr;
    logic commit;
    logic report;
  } ctl_t;

  typedef struct packed {
    logic lo_eq_hi;
    logic found;
    logic full;
    logic mv_last;
    logic is_ins;
    logic is_rem;
  } sts_t;

endpackage

FILE: rtl/sss_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module sss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/sss_ctrl.sv
// Controller of the sorted set store: binary search, shift loop and result sequencing.
module sss_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  sss_pkg::sts_t sts_i,
  output sss_pkg::ctl_t ctl_o,
  output logic          busy_o
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SRCH = 6'b000010,
    ST_CMP  = 6'b000100,
    ST_MOVE = 6'b001000,
    ST_MVWR = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   go_move;

  assign go_move = (sts_i.is_ins && !sts_i.found && !sts_i.full) ||
                   (sts_i.is_rem && sts_i.found);

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          ctl_o.load = 1'b1;
          state_d    = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (sts_i.lo_eq_hi) begin
          if (go_move) begin
            ctl_o.mv_init = 1'b1;
            state_d       = ST_MOVE;
          end else begin
            state_d = ST_DONE;
          end
        end else begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        ctl_o.srch_cmp = 1'b1;
        state_d        = ST_SRCH;
      end
      ST_MOVE: begin
        if (sts_i.mv_last) begin
          ctl_o.commit = 1'b1;
          state_d      = ST_DONE;
        end else begin
          ctl_o.mv_rd = 1'b1;
          state_d     = ST_MVWR;
        end
      end
      ST_MVWR: begin
        ctl_o.mv_wr = 1'b1;
        state_d     = ST_MOVE;
      end
      ST_DONE: begin
        ctl_o.report = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

FILE: rtl/sss_dp.sv
// Datapath of the sorted set store: element RAM, search bounds, shift index and result registers.
module sss_dp #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         cmd_i,
  input  logic signed [31:0] value_i,
  input  sss_pkg::ctl_t      ctl_i,
  output sss_pkg::sts_t      sts_o,
  output logic               done_o,
  output logic               was_member_o,
  output logic               dropped_o,
  output logic [6:0]         count_o,
  output logic               is_empty_o
);

  sss_pkg::cmd_e      cmd_q, cmd_d;
  logic signed [31:0] val_q, val_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [CW-1:0]      lo_q, lo_d;
  logic [CW-1:0]      hi_q, hi_d;
  logic               found_q, found_d;
  logic               ins_ok_q, ins_ok_d;
  logic [AW-1:0]      j_q, j_d;
  logic               done_q, done_d;
  logic               was_member_q, was_member_d;
  logic               dropped_q, dropped_d;
  logic [6:0]         count_q, count_d;
  logic               is_empty_q, is_empty_d;

  logic [CW:0]        sum_w;
  logic [CW-1:0]      mid_w;
  logic               is_ins, is_rem, is_clr, full;

  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [31:0]        wdata, rdata;
  logic signed [31:0] rdata_s;

  sss_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign rdata_s = $signed(rdata);
  assign sum_w   = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_w   = sum_w[CW:1];
  assign is_ins  = (cmd_q == sss_pkg::CMD_INSERT);
  assign is_rem  = (cmd_q == sss_pkg::CMD_REMOVE);
  assign is_clr  = (cmd_q == sss_pkg::CMD_CLEAR);
  assign full    = (cnt_q == CW'(DEPTH));

  assign sts_o.lo_eq_hi = (lo_q == hi_q);
  assign sts_o.found    = found_q;
  assign sts_o.full     = full;
  assign sts_o.mv_last  = is_ins ? (CW'(j_q) == lo_q) : ((CW'(j_q) + CW'(1)) == cnt_q);
  assign sts_o.is_ins   = is_ins;
  assign sts_o.is_rem   = is_rem;

  always_comb begin
    cmd_d        = cmd_q;
    val_d        = val_q;
    cnt_d        = cnt_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    found_d      = found_q;
    ins_ok_d     = ins_ok_q;
    j_d          = j_q;
    done_d       = 1'b0;
    was_member_d = was_member_q;
    dropped_d    = dropped_q;
    count_d      = count_q;
    is_empty_d   = is_empty_q;
    we           = 1'b0;
    waddr        = j_q;
    wdata        = rdata;
    raddr        = mid_w[AW-1:0];

    if (ctl_i.load) begin
      cmd_d    = sss_pkg::cmd_e'(cmd_i);
      val_d    = value_i;
      lo_d     = '0;
      hi_d     = cnt_q;
      found_d  = 1'b0;
      ins_ok_d = 1'b0;
    end
    if (ctl_i.srch_cmp) begin
      if (rdata_s < val_q) begin
        lo_d = mid_w + CW'(1);
      end else begin
        hi_d = mid_w;
      end
      if (rdata_s == val_q) begin
        found_d = 1'b1;
      end
    end
    if (ctl_i.mv_init) begin
      j_d = is_ins ? cnt_q[AW-1:0] : lo_q[AW-1:0];
    end
    if (ctl_i.mv_rd) begin
      raddr = is_ins ? (j_q - AW'(1)) : (j_q + AW'(1));
    end
    if (ctl_i.mv_wr) begin
      we  = 1'b1;
      j_d = is_ins ? (j_q - AW'(1)) : (j_q + AW'(1));
    end
    if (ctl_i.commit) begin
      if (is_ins) begin
        we       = 1'b1;
        wdata    = val_q;
        cnt_d    = cnt_q + CW'(1);
        ins_ok_d = 1'b1;
      end else begin
        cnt_d = cnt_q - CW'(1);
      end
    end
    if (ctl_i.report) begin
      if (is_clr) begin
        cnt_d = '0;
      end
      done_d       = 1'b1;
      was_member_d = found_q;
      dropped_d    = is_ins && !found_q && !ins_ok_q;
      count_d      = 7'(cnt_d);
      is_empty_d   = (cnt_d == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    val_q        <= val_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    found_q      <= found_d;
    ins_ok_q     <= ins_ok_d;
    j_q          <= j_d;
    was_member_q <= was_member_d;
    dropped_q    <= dropped_d;
    count_q      <= count_d;
    is_empty_q   <= is_empty_d;
  end

  assign done_o       = done_q;
  assign was_member_o = was_member_q;
  assign dropped_o    = dropped_q;
  assign count_o      = count_q;
  assign is_empty_o   = is_empty_q;

endmodule

FILE: rtl/sorted_set_store.sv
// Top level of the sorted set store: ascending set of distinct signed 32-bit values.
//
// Usage: drive cmd_i (query, insert, remove, clear) and value_i with start_i high;
// the beat is taken at a rising edge where start_i is high and busy_o is low.
// busy_o rises the cycle after and stays high while the command runs.
// Each command gives one result beat: done_o is high for exactly one cycle with
// was_member_o, dropped_o, count_o and is_empty_o valid; the receiver cannot stall,
// so the beat must be captured in that cycle. busy_o is already low in that cycle,
// so the next command may be started alongside the result.
// A command makes S <= clog2(count+1) binary search probes of the element RAM and,
// when the set changes by insert or remove, shifts M entries (count-pos for an
// insert, count-pos-1 for a remove). The RAM has a single read port; each shifted
// entry is read and then written once.
// Reset clears the element count and the result strobe; RAM contents are not
// cleared, since entries at or beyond the count are never read.
module sorted_set_store #(
  parameter int DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [1:0]  cmd_i,
  input  logic signed [31:0] value_i,
  output logic        busy_o,
  output logic        done_o,
  output logic        was_member_o,
  output logic        dropped_o,
  output logic [6:0]  count_o,
  output logic        is_empty_o
);

  sss_pkg::ctl_t ctl;
  sss_pkg::sts_t sts;

  sss_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .sts_i  (sts),
    .ctl_o  (ctl),
    .busy_o (busy_o)
  );

  sss_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .value_i     (value_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .done_o      (done_o),
    .was_member_o(was_member_o),
    .dropped_o   (dropped_o),
    .count_o     (count_o),
    .is_empty_o  (is_empty_o)
  );

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted command did not raise busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result beat while busy");

  a_drop_not_member: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && dropped_o) |-> !was_member_o)
    else $error("dropped insert of a present value");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && is_empty_o) |-> (count_o == 7'd0))
    else $error("empty flag with nonzero count");

endmodule

FILE: bench/sorted_set_store_tb.sv
// Testbench for sorted_set_store: directed, full-store and random command checks.
`timescale 1ns / 1ps

module sorted_set_store_tb;

  localparam int DEPTH = 64;
  localparam int IDLE_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 200;
  localparam int RANDOM_BEATS = 1000;
  localparam int POOL_SIZE = 96;
  localparam int VAL_MAX = 32'h7fff_ffff;
  localparam int VAL_MIN = 32'h8000_0000;

  typedef struct {
    logic       was_member;
    logic       dropped;
    logic [6:0] count;
    logic       is_empty;
  } set_status_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic [1:0]         cmd_i;
  logic signed [31:0] value_i;
  logic               busy_o;
  logic               done_o;
  logic               was_member_o;
  logic               dropped_o;
  logic [6:0]         count_o;
  logic               is_empty_o;

  int          set_vals [DEPTH];
  int          set_size;
  set_status_t status_q [$];
  set_status_t head_status;
  int          mismatch_count;
  int          beats_sent;
  int          burst_left;
  int          idle_count;
  int          value_pool [POOL_SIZE];

  sorted_set_store #(.DEPTH(DEPTH)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .cmd_i        (cmd_i),
    .value_i      (value_i),
    .busy_o       (busy_o),
    .done_o       (done_o),
    .was_member_o (was_member_o),
    .dropped_o    (dropped_o),
    .count_o      (count_o),
    .is_empty_o   (is_empty_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // applies one command to the shadow set and returns the status it should report
  function automatic set_status_t predict_set_op(sss_pkg::cmd_e op, int v);
    set_status_t r;
    int          pos;
    logic        hit;
    pos = 0;
    while (pos < set_size && set_vals[pos] < v) pos++;
    hit = (pos < set_size) && (set_vals[pos] == v);
    r.dropped = 1'b0;
    case (op)
      sss_pkg::CMD_INSERT: begin
        if (!hit) begin
          if (set_size >= DEPTH) begin
            r.dropped = 1'b1;
          end else begin
            for (int j = set_size; j > pos; j--) set_vals[j] = set_vals[j-1];
            set_vals[pos] = v;
            set_size++;
          end
        end
      end
      sss_pkg::CMD_REMOVE: begin
        if (hit) begin
          for (int j = pos; j + 1 < set_size; j++) set_vals[j] = set_vals[j+1];
          set_size--;
        end
      end
      sss_pkg::CMD_CLEAR: begin
        set_size = 0;
      end
      default: ;
    endcase
    r.was_member = hit;
    r.count      = set_size[6:0];
    r.is_empty   = (set_size == 0);
    return r;
  endfunction

  function automatic logic set_holds(int v);
    for (int i = 0; i < set_size; i++) if (set_vals[i] == v) return 1'b1;
    return 1'b0;
  endfunction

  function automatic sss_pkg::cmd_e pick_op(int ins_pct, int rem_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < ins_pct) return sss_pkg::CMD_INSERT;
    if (r < ins_pct + rem_pct) return sss_pkg::CMD_REMOVE;
    if (r == 99) return sss_pkg::CMD_CLEAR;
    return sss_pkg::CMD_QUERY;
  endfunction

  function automatic int pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return value_pool[$urandom_range(0, POOL_SIZE - 1)];
      5, 6: begin
        if (set_size > 0) return set_vals[$urandom_range(0, set_size - 1)];
        return $urandom;
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic flag_mismatch(string what, int expv, int gotv);
    mismatch_count++;
    if (mismatch_count <= 50)
      $display("MISMATCH %s: expected %0d got %0d at %0t", what, expv, gotv, $realtime);
  endtask

  // one command beat; start stays high into the next beat unless a gap is due
  task automatic send_beat(sss_pkg::cmd_e op, int v);
    start_i <= 1'b1;
    cmd_i   <= op;
    value_i <= v;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    status_q.push_back(predict_set_op(op, v));
    beats_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(80, 200)
                                               : $urandom_range(1, 24);
    end
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    do @(posedge clk_i); while (status_q.size() != 0);
  endtask

  task automatic test_directed();
    send_beat(sss_pkg::CMD_QUERY, 0);
    send_beat(sss_pkg::CMD_REMOVE, 5);
    send_beat(sss_pkg::CMD_INSERT, 0);
    send_beat(sss_pkg::CMD_INSERT, VAL_MAX);
    send_beat(sss_pkg::CMD_INSERT, VAL_MIN);
    send_beat(sss_pkg::CMD_INSERT, -1);
    send_beat(sss_pkg::CMD_INSERT, 1);
    send_beat(sss_pkg::CMD_INSERT, VAL_MAX);
    send_beat(sss_pkg::CMD_QUERY, VAL_MIN);
    send_beat(sss_pkg::CMD_QUERY, 2);
    send_beat(sss_pkg::CMD_QUERY, -2);
    send_beat(sss_pkg::CMD_QUERY, 32'h5555_5555);
    send_beat(sss_pkg::CMD_QUERY, 32'haaaa_aaaa);
    send_beat(sss_pkg::CMD_REMOVE, 0);
    send_beat(sss_pkg::CMD_REMOVE, 0);
    send_beat(sss_pkg::CMD_REMOVE, VAL_MIN);
    send_beat(sss_pkg::CMD_REMOVE, VAL_MAX);
    send_beat(sss_pkg::CMD_INSERT, -1);
    send_beat(sss_pkg::CMD_CLEAR, 1);
    send_beat(sss_pkg::CMD_CLEAR, 7);
    send_beat(sss_pkg::CMD_QUERY, -1);
    send_beat(sss_pkg::CMD_INSERT, 42);
    send_beat(sss_pkg::CMD_CLEAR, 42);
  endtask

  task automatic test_full_store();
    int v;
    send_beat(sss_pkg::CMD_CLEAR, $urandom);
    // descending fill puts every new value at the front: longest shifts
    v = VAL_MAX;
    while (set_size < DEPTH) begin
      send_beat(sss_pkg::CMD_INSERT, v);
      v -= $urandom_range(1, 1 << 20);
    end
    do v = $urandom; while (set_holds(v));
    send_beat(sss_pkg::CMD_INSERT, v);
    send_beat(sss_pkg::CMD_INSERT, VAL_MAX);
    send_beat(sss_pkg::CMD_QUERY, VAL_MAX);
    send_beat(sss_pkg::CMD_REMOVE, set_vals[0]);
    send_beat(sss_pkg::CMD_INSERT, VAL_MIN);
    send_beat(sss_pkg::CMD_INSERT, VAL_MIN + 1);
    wait_drained();
    send_beat(sss_pkg::CMD_REMOVE, set_vals[DEPTH-1]);
    send_beat(sss_pkg::CMD_INSERT, VAL_MIN + 1);
    send_beat(sss_pkg::CMD_CLEAR, set_vals[5]);
  endtask

  task automatic test_random_mix();
    int stop_at;
    for (int i = 0; i < POOL_SIZE; i++)
      value_pool[i] = (i < 24) ? i - 12 : int'($urandom);
    value_pool[0] = VAL_MIN;
    value_pool[1] = VAL_MIN + 1;
    value_pool[2] = VAL_MAX;
    value_pool[3] = VAL_MAX - 1;
    stop_at = beats_sent + RANDOM_BEATS;
    while (beats_sent < stop_at) begin
      for (int k = $urandom_range(20, 130); k > 0 && beats_sent < stop_at; k--)
        send_beat(pick_op(70, 12), pick_value());
      for (int k = $urandom_range(20, 130); k > 0 && beats_sent < stop_at; k--)
        send_beat(pick_op(15, 60), pick_value());
      if ($urandom_range(0, 3) == 0) wait_drained();
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (status_q.size() == 0) begin
        flag_mismatch("unexpected result beat", 0, 1);
      end else begin
        head_status = status_q.pop_front();
        if (was_member_o !== head_status.was_member)
          flag_mismatch("was_member", head_status.was_member, was_member_o);
        if (dropped_o !== head_status.dropped)
          flag_mismatch("dropped", head_status.dropped, dropped_o);
        if (count_o !== head_status.count)
          flag_mismatch("count", head_status.count, count_o);
        if (is_empty_o !== head_status.is_empty)
          flag_mismatch("is_empty", head_status.is_empty, is_empty_o);
      end
    end
  end

  // watchdog: no beat in either direction for too long
  initial begin
    idle_count = 0;
    forever begin
      @(posedge clk_i);
      if ((start_i && busy_o === 1'b0) || done_o === 1'b1) idle_count = 0;
      else idle_count++;
      if (idle_count >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni         <= 1'b0;
    start_i        <= 1'b0;
    cmd_i          <= sss_pkg::CMD_QUERY;
    value_i        <= '0;
    mismatch_count = 0;
    beats_sent     = 0;
    set_size       = 0;
    burst_left     = 10;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    wait_drained();
    test_full_store();
    wait_drained();
    test_random_mix();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (status_q.size() != 0) flag_mismatch("results never arrived", 0, status_q.size());
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
